// File: rtl/sha256_stream_hasher_unit_defines.svh
// ----------------------------------------------------------------------------
// SHA-256 stream hasher assertion macros
// Shared property forms used by the hasher's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SHA256_STREAM_HASHER_UNIT_DEFINES_SVH
`define SHA256_STREAM_HASHER_UNIT_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define SHS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Condition that must hold in the cycle after the antecedent.
`define SHS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/shs_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Round constants, initial hash values and round helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package shs_pkg;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam int unsigned LEN_POS = 56;

	typedef logic [31:0] word_t;

	// Status passed from the round engine back to the controller.
	typedef struct packed {
		logic busy;
		logic done;
	} eng_status_t;

	function automatic word_t round_k(input logic [5:0] idx);
		word_t k;
		unique case (idx)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	function automatic word_t init_hash(input logic [2:0] idx);
		word_t h;
		unique case (idx)
			3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
			3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
			3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
			3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
		endcase
		return h;
	endfunction

	function automatic word_t rotr(input word_t x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic word_t big_s0(input word_t a);
		return rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
	endfunction

	function automatic word_t big_s1(input word_t e);
		return rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
	endfunction

	function automatic word_t small_s0(input word_t x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t small_s1(input word_t x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

`default_nettype wire

// File: rtl/sha256_stream_hasher_unit.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Absorbs one message byte per item, compresses each full 64-byte block and
// emits the eight digest words at end of message.
// ----------------------------------------------------------------------------
//  channel | payload                                 | handshake
//  in      | data_byte, byte_valid, end_of_message   | in_valid / in_stall
//  out     | digest_word, word_index, last_word      | out_valid / out_stall
//
//  A byte that does not fill the block is absorbed without an input stall.
//  A byte that fills the block holds the input while the controller starts
//  the round engine, the engine runs its rounds and adds the chaining words,
//  and the controller sees the engine finish and returns to idle.
//  End of message writes padding one byte per cycle and then runs one or
//  two compressions before the eight digest items leave.
//  Reset is asynchronous and restores the initial hash values; the byte
//  buffer needs no clearing. An output stall holds the current digest item.
//  After the last digest item is taken, the input reopens via ST_REINIT.
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_stream_hasher_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        byte_valid,
	input  wire logic        end_of_message,
	output      logic        out_valid,
	input  wire logic        out_stall,
	output      logic [31:0] digest_word,
	output      logic [2:0]  word_index,
	output      logic        last_word
);

`include "sha256_stream_hasher_unit_defines.svh"

	typedef enum logic [2:0] {
		ST_IDLE, ST_COMP, ST_PAD, ST_FINAL, ST_OUT, ST_REINIT
	} ctl_state_t;

	ctl_state_t              state_q;
	logic [5:0]              fill_q;
	logic [63:0]             bits_q;
	logic [63:0]             total_q;
	logic                    fin_q;      // end of message pending after compress
	logic                    last_pass_q;// pad pass carries the length field
	logic                    pad_open_q; // padding has begun for this message
	logic [2:0]              widx_q;
	logic                    wr_en;
	logic [5:0]              wr_addr;
	logic [7:0]              wr_data;
	logic                    eng_start;
	logic                    eng_reinit;
	logic [511:0]            block;
	shs_pkg::word_t          rd_word;
	shs_pkg::eng_status_t    eng_status;
	logic                    in_acc;
	logic [5:0]              len_sel;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;

	// Length byte for the pad position: big-endian bytes of the total.
	assign len_sel = fill_q - 6'(shs_pkg::LEN_POS);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = fill_q;
		wr_data = data_byte;
		if (in_acc && byte_valid) begin
			wr_en = 1'b1;
		end else if (state_q == ST_PAD) begin
			wr_en = 1'b1;
			if (last_pass_q && fill_q >= 6'(shs_pkg::LEN_POS))
				wr_data = total_q[63 - 8*len_sel[2:0] -: 8];
			else
				wr_data = 8'h00;
		end else if (state_q == ST_FINAL) begin
			wr_en   = 1'b1;
			wr_data = shs_pkg::PAD_BYTE;
		end
	end

	shs_block_buffer u_buf (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.block   (block)
	);

	shs_round_engine u_eng (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (eng_start),
		.block   (block),
		.reinit  (eng_reinit),
		.rd_idx  (widx_q),
		.rd_word (rd_word),
		.status  (eng_status)
	);

	// Controller. ST_FINAL writes the 0x80 byte; ST_PAD fills zeros and, on
	// the last pass, the length; ST_COMP waits for the engine. After a pad
	// block without the length, one more pad pass follows from byte zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			bits_q      <= '0;
			total_q     <= '0;
			fin_q       <= 1'b0;
			last_pass_q <= 1'b0;
			pad_open_q  <= 1'b0;
			widx_q      <= '0;
			eng_start   <= 1'b0;
			eng_reinit  <= 1'b0;
		end else begin
			eng_start  <= 1'b0;
			eng_reinit <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						fin_q <= end_of_message;
						if (byte_valid) begin
							fill_q <= fill_q + 6'd1;
							if (fill_q == 6'd63) begin
								eng_start <= 1'b1;
								state_q   <= ST_COMP;
							end else if (end_of_message) begin
								state_q <= ST_FINAL;
							end
						end else if (end_of_message) begin
							state_q <= ST_FINAL;
						end
					end
				end
				ST_COMP: begin
					if (eng_status.done) begin
						if (!pad_open_q) bits_q <= bits_q + 64'd512;
						if (last_pass_q) begin
							widx_q  <= '0;
							state_q <= ST_OUT;
						end else if (pad_open_q) begin
							last_pass_q <= 1'b1;
							state_q     <= ST_PAD;
						end else if (fin_q) begin
							state_q <= ST_FINAL;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_FINAL: begin
					// Byte count is fill_q; 0x80 goes there.
					total_q     <= bits_q + {55'd0, fill_q, 3'd0};
					fill_q      <= fill_q + 6'd1;
					last_pass_q <= (fill_q < 6'(shs_pkg::LEN_POS));
					fin_q       <= 1'b0;
					pad_open_q  <= 1'b1;
					if (fill_q == 6'd63) begin
						eng_start <= 1'b1;
						state_q   <= ST_COMP;
					end else begin
						state_q <= ST_PAD;
					end
				end
				ST_PAD: begin
					fill_q <= fill_q + 6'd1;
					if (fill_q == 6'd63) begin
						eng_start <= 1'b1;
						state_q   <= ST_COMP;
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						widx_q <= widx_q + 3'd1;
						if (widx_q == 3'd7) begin
							eng_reinit  <= 1'b1;
							fill_q      <= '0;
							bits_q      <= '0;
							fin_q       <= 1'b0;
							last_pass_q <= 1'b0;
							pad_open_q  <= 1'b0;
							state_q     <= ST_REINIT;
						end
					end
				end
				ST_REINIT: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid   = (state_q == ST_OUT);
	assign digest_word = rd_word;
	assign word_index  = widx_q;
	assign last_word   = (widx_q == 3'd7);

	`SHS_ASSERT_IMPL(a_no_out_while_busy, clk, arst_n, eng_status.busy, !out_valid,
		"digest item shown while the round engine runs")
	`SHS_ASSERT_IMPL(a_last_is_seven, clk, arst_n, out_valid && last_word,
		word_index == 3'd7, "last digest item at a wrong index")
	`SHS_ASSERT_NEXT(a_start_busy, clk, arst_n, eng_start && !eng_status.busy,
		eng_status.busy, "round engine did not start")

endmodule

`default_nettype wire

// File: rtl/shs_round_engine.sv
// ----------------------------------------------------------------------------
// SHA-256 round engine
// Runs the 64 compression rounds, one per cycle, over a 16-word schedule
// window, then adds the working variables into the chaining words.
// ----------------------------------------------------------------------------
`default_nettype none

module shs_round_engine (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [511:0]         block,
	input  wire logic                 reinit,
	input  wire logic [2:0]           rd_idx,
	output      shs_pkg::word_t       rd_word,
	output      shs_pkg::eng_status_t status
);

	typedef enum logic [1:0] {ENG_IDLE, ENG_ROUND, ENG_ADD} eng_state_t;

	eng_state_t       state_q;
	logic [5:0]       round_q;
	shs_pkg::word_t   hash_q [8];
	shs_pkg::word_t   v_q [8];
	shs_pkg::word_t   w_q [16];
	shs_pkg::word_t   t1;
	shs_pkg::word_t   t2;
	shs_pkg::word_t   w_new;
	logic             done_q;

	// The window head is the current round's word; the word pushed in is
	// the schedule word sixteen rounds ahead.
	always_comb begin
		t1 = v_q[7] + shs_pkg::big_s1(v_q[4])
			+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
			+ shs_pkg::round_k(round_q) + w_q[0];
		t2 = shs_pkg::big_s0(v_q[0])
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		w_new = shs_pkg::small_s1(w_q[14]) + w_q[9] + shs_pkg::small_s0(w_q[1]) + w_q[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ENG_IDLE;
			round_q <= '0;
			done_q  <= 1'b0;
			for (int i = 0; i < 8; i++) hash_q[i] <= shs_pkg::init_hash(3'(i));
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ENG_IDLE: begin
					if (reinit) begin
						for (int i = 0; i < 8; i++) hash_q[i] <= shs_pkg::init_hash(3'(i));
					end else if (start) begin
						for (int i = 0; i < 16; i++) w_q[i] <= block[511 - 32*i -: 32];
						for (int i = 0; i < 8; i++) v_q[i] <= hash_q[i];
						round_q <= '0;
						state_q <= ENG_ROUND;
					end
				end
				ENG_ROUND: begin
					for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
					w_q[15] <= w_new;
					v_q[0] <= t1 + t2;
					v_q[1] <= v_q[0];
					v_q[2] <= v_q[1];
					v_q[3] <= v_q[2];
					v_q[4] <= v_q[3] + t1;
					v_q[5] <= v_q[4];
					v_q[6] <= v_q[5];
					v_q[7] <= v_q[6];
					round_q <= round_q + 6'd1;
					if (round_q == 6'd63) state_q <= ENG_ADD;
				end
				ENG_ADD: begin
					for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + v_q[i];
					done_q  <= 1'b1;
					state_q <= ENG_IDLE;
				end
				default: state_q <= ENG_IDLE;
			endcase
		end
	end

	assign rd_word     = hash_q[rd_idx];
	assign status.busy = (state_q != ENG_IDLE);
	assign status.done = done_q;

endmodule

`default_nettype wire

// File: rtl/shs_block_buffer.sv
// ----------------------------------------------------------------------------
// SHA-256 block buffer
// Word memory of one 64-byte block, sixteen big-endian words, with one byte
// lane written per cycle. No clearing is needed: every byte is written before
// each compression starts.
// ----------------------------------------------------------------------------
`default_nettype none

module shs_block_buffer (
	input  wire logic         clk,
	input  wire logic         wr_en,
	input  wire logic [5:0]   wr_addr,
	input  wire logic [7:0]   wr_data,
	output      logic [511:0] block
);

	logic [31:0] mem_q [16];

	// Byte address bits [5:2] pick the word, bits [1:0] the lane, with the
	// lowest byte address in the most significant lane.
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr[5:2]][31 - 8*wr_addr[1:0] -: 8] <= wr_data;
	end

	always_comb begin
		for (int i = 0; i < 16; i++) block[511 - 32*i -: 32] = mem_q[i];
	end

endmodule

`default_nettype wire

// File: sim/sha256_stream_hasher_unit_tb.sv
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Feeds byte items with random gaps, computes the expected digests with a
// software hash kept in step with every accepted item, and checks each digest
// item as it leaves the block under random output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha256_stream_hasher_unit_tb;

	typedef struct packed {
		logic [7:0] data;
		logic       has_byte;
		logic       eom;
	} byte_item_t;

	typedef struct packed {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_item_t;

	localparam int unsigned WATCHDOG_LIMIT = 20000;
	localparam int unsigned DRAIN_CYCLES   = 200;
	localparam int unsigned BLOCK_BYTES    = 64;

	// The round constants and initial hash values are the standard tables,
	// kept here so the predictor does not lean on the package functions.
	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
		32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
		32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
		32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
		32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
		32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
		32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
		32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
		32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
		32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};
	localparam logic [31:0] IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        byte_valid;
	logic        end_of_message;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	sha256_stream_hasher_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.byte_valid    (byte_valid),
		.end_of_message(end_of_message),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.digest_word   (digest_word),
		.word_index    (word_index),
		.last_word     (last_word)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Predictor state: running hash, partial block, fill level and bit count.
	logic [31:0] chain_h [8];
	logic [7:0]  msg_block [64];
	logic [5:0]  fill_level;
	logic [63:0] msg_bits;

	byte_item_t   pending_items [$];
	digest_item_t digest_queue [$];

	int unsigned errors;
	int unsigned messages_done;
	int unsigned digest_words_seen;
	int unsigned idle_cycles;
	bit          stimulus_done;
	bit          no_idle;   // disables random gaps on both sides
	bit          hold_off;  // sender waits until all digests are out
	bit          in_took;   // the input item was accepted at the last rising edge

	function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic compress_msg_block();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1;
		logic [31:0] t2;
		logic [31:0] s0;
		logic [31:0] s1;
		for (int i = 0; i < 16; i++)
			w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
		for (int i = 16; i < 64; i++) begin
			s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = s1 + w[i-7] + s0 + w[i-16];
		end
		for (int i = 0; i < 8; i++)
			v[i] = chain_h[i];
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
			   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + w[i];
			t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
			   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			chain_h[i] = chain_h[i] + v[i];
	endtask

	task automatic restart_message();
		for (int i = 0; i < 8; i++)
			chain_h[i] = IV[i];
		fill_level = '0;
		msg_bits   = '0;
	endtask

	// Updates the hash state for one accepted item and queues any digest.
	task automatic absorb_item(input byte_item_t it);
		int unsigned pos;
		logic [63:0] total;
		digest_item_t d;
		if (it.has_byte) begin
			msg_block[fill_level] = it.data;
			if (fill_level == 6'd63) begin
				compress_msg_block();
				msg_bits   = msg_bits + 64'd512;
				fill_level = '0;
			end else begin
				fill_level = fill_level + 6'd1;
			end
		end
		if (it.eom) begin
			pos   = fill_level;
			total = msg_bits + 64'(pos * 8);
			msg_block[pos] = shs_pkg::PAD_BYTE;
			pos++;
			if (pos > shs_pkg::LEN_POS) begin
				while (pos < BLOCK_BYTES) begin
					msg_block[pos] = 8'h00;
					pos++;
				end
				compress_msg_block();
				pos = 0;
			end
			while (pos < shs_pkg::LEN_POS) begin
				msg_block[pos] = 8'h00;
				pos++;
			end
			for (int i = 0; i < 8; i++)
				msg_block[shs_pkg::LEN_POS + i] = total[63 - 8*i -: 8];
			compress_msg_block();
			for (int i = 0; i < 8; i++) begin
				d.word = chain_h[i];
				d.idx  = 3'(i);
				d.last = (i == 7);
				digest_queue.push_back(d);
			end
			messages_done++;
			restart_message();
		end
	endtask

	function automatic byte_item_t make_item(input logic [7:0] b, input logic v,
			input logic e);
		byte_item_t it;
		it.data     = b;
		it.has_byte = v;
		it.eom      = e;
		return it;
	endfunction

	// Queues a message of n random bytes; the last byte may carry the end flag
	// or the end may come as a separate empty item. Idle items are sprinkled in.
	task automatic queue_message(input int unsigned n);
		bit end_on_byte;
		end_on_byte = (n > 0) && $urandom_range(0, 1);
		for (int unsigned i = 0; i < n; i++) begin
			if ($urandom_range(0, 19) == 0)
				pending_items.push_back(make_item(8'($urandom), 1'b0, 1'b0));
			pending_items.push_back(make_item(8'($urandom), 1'b1,
				end_on_byte && (i == n - 1)));
		end
		if (!end_on_byte)
			pending_items.push_back(make_item(8'($urandom), 1'b0, 1'b1));
	endtask

	// Driver: presents the head of the queue at the falling edge, and only
	// drops or replaces it after the monitor has seen it accepted.
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_took) begin
				void'(pending_items.pop_front());
			end
			if (in_valid && !in_took) begin
				// The stalled item stays on the bus unchanged.
			end else if (pending_items.size() != 0 && !hold_off
					&& (no_idle || $urandom_range(0, 99) >= 30)) begin
				in_valid       <= 1'b1;
				data_byte      <= pending_items[0].data;
				byte_valid     <= pending_items[0].has_byte;
				end_of_message <= pending_items[0].eom;
			end else begin
				in_valid <= 1'b0;
			end
			out_stall <= !no_idle && ($urandom_range(0, 99) < 30);
		end
	end

	// Monitor: the predictor advances on every accepted input item, and each
	// accepted digest item is checked against the oldest expectation.
	always @(posedge clk) begin
		digest_item_t exp_d;
		if (arst_n) begin
			in_took = in_valid && !in_stall;
			if (in_valid && !in_stall)
				absorb_item(make_item(data_byte, byte_valid, end_of_message));
			if (out_valid && !out_stall) begin
				digest_words_seen++;
				if (digest_queue.size() == 0) begin
					errors++;
					$display("%0t: unexpected digest item word=%h index=%0d last=%b",
						$time, digest_word, word_index, last_word);
				end else begin
					exp_d = digest_queue.pop_front();
					if (digest_word !== exp_d.word) begin
						errors++;
						$display("%0t: digest_word expected %h actual %h",
							$time, exp_d.word, digest_word);
					end
					if (word_index !== exp_d.idx) begin
						errors++;
						$display("%0t: word_index expected %0d actual %0d",
							$time, exp_d.idx, word_index);
					end
					if (last_word !== exp_d.last) begin
						errors++;
						$display("%0t: last_word expected %b actual %b",
							$time, exp_d.last, last_word);
					end
				end
			end
		end else begin
			in_took = 1'b0;
		end
	end

	// Watchdog: counts cycles in which neither channel moves an item.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (pending_items.size() != 0 || digest_queue.size() != 0
				|| !stimulus_done) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		int unsigned n;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		data_byte      = '0;
		byte_valid     = 1'b0;
		end_of_message = 1'b0;
		out_stall      = 1'b0;
		errors         = 0;
		messages_done  = 0;
		digest_words_seen = 0;
		idle_cycles    = 0;
		stimulus_done  = 1'b0;
		no_idle        = 1'b0;
		hold_off       = 1'b0;
		in_took        = 1'b0;
		restart_message();
		for (int i = 0; i < 64; i++)
			msg_block[i] = '0;

		// Directed part: empty message, idle item, byte with end together,
		// extreme byte values, and the one-block-versus-two padding boundary.
		pending_items.push_back(make_item(8'h00, 1'b0, 1'b1));
		pending_items.push_back(make_item(8'hff, 1'b0, 1'b0));
		pending_items.push_back(make_item(8'h00, 1'b1, 1'b1));
		pending_items.push_back(make_item(8'hff, 1'b1, 1'b0));
		pending_items.push_back(make_item(8'haa, 1'b1, 1'b0));
		pending_items.push_back(make_item(8'h55, 1'b1, 1'b1));
		pending_items.push_back(make_item(8'h00, 1'b0, 1'b1));
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Messages whose length lands on each side of the padding boundary
		// and on the block boundary.
		queue_message(55);
		queue_message(56);
		queue_message(63);
		queue_message(64);

		// Pause the sender until every digest is out.
		wait (pending_items.size() == 0);
		hold_off = 1'b1;
		wait (digest_queue.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		hold_off = 1'b0;

		// Random part: short messages and one multi-block message; a stretch
		// around the long one runs with no gaps or stalls.
		for (int m = 0; m < 8; m++) begin
			if (m == 5)
				n = $urandom_range(66, 80);
			else
				n = $urandom_range(0, 8);
			if (m == 3)
				no_idle = 1'b1;
			if (m == 7)
				no_idle = 1'b0;
			queue_message(n);
			wait (pending_items.size() < 8);
		end

		wait (pending_items.size() == 0 && !in_valid);
		stimulus_done = 1'b1;
		wait (digest_queue.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Hashed %0d messages, checked %0d digest words, covering empty,",
			messages_done, digest_words_seen);
		$display("padding-boundary and multi-block messages under random stalls.");
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
